// ----- sv/kef_pkg.sv -----
// Package for the Kruskal edge filter: vertex sizing, the item and result
// structs, the queue entry and the queue status struct.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package kef_pkg;

	localparam int VERTICES = 1024;
	localparam int IDX_W    = $clog2(VERTICES);
	localparam int VTX_W    = 10;
	localparam int WEIGHT_W = 24;
	localparam int RANK_W   = 4;
	localparam logic [RANK_W-1:0] RANK_MAX = '1;
	localparam logic [VTX_W:0] VTX_LIMIT = (VTX_W+1)'(VERTICES);

	typedef struct packed {
		logic [VTX_W-1:0]    end_a;
		logic [VTX_W-1:0]    end_b;
		logic [WEIGHT_W-1:0] weight;
		logic                final_edge;
	} edge_in_t;

	typedef struct packed {
		logic                tree_edge;
		logic [VTX_W-1:0]    out_end_a;
		logic [VTX_W-1:0]    out_end_b;
		logic [WEIGHT_W-1:0] out_weight;
		logic                out_final;
	} edge_out_t;

	// One queued job: the edge and whether it can be rejected without a walk.
	typedef struct packed {
		edge_in_t e;
		logic     skip;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Memory index of a vertex number.
	function automatic logic [IDX_W-1:0] vidx(input logic [VTX_W-1:0] v);
		return v[IDX_W-1:0];
	endfunction

endpackage

// ----- sv/kruskal_edge_filter.sv -----
// Top level of the Kruskal edge filter (union-find by rank, no path
// compression). Depends on kef_pkg, kef_front, kef_fifo and kef_back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         start high, busy low      edge_in (edge_in_t)
// result    out        done high for one cycle   result (edge_out_t)
//
// An edge that needs root walks is popped, and the back end then visits each
// vertex on its two root walks in turn through the forest memory's single read
// port. The union write happens in the same cycle as the last step of the second
// walk, and when both ranks are equal the S_BUMP state then raises the winner's
// rank. With 1024 vertices a walk is at most ten links deep. A self loop or an
// out-of-range vertex is answered in its pop cycle without any walk. The result
// is registered, so it appears in the cycle after the edge finishes.
// After reset, and after every edge marked final, a clearing pass writes all
// VERTICES forest entries, one per cycle; busy is high meanwhile.
// The front end and a two-entry queue take items while the back end walks;
// busy rises only when they are full or clearing. Results cannot be held off.

module kruskal_edge_filter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  kef_pkg::edge_in_t  edge_in,
	output logic               done,
	output kef_pkg::edge_out_t result
);
	import kef_pkg::*;

	// Queue traffic between the front end and the back end.
	logic    push;
	job_t    push_job;
	logic    pop;
	job_t    head;
	q_stat_t q_st;
	// High while the back end rewrites the forest to its empty state.
	logic    clearing;

	kef_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.edge_in  (edge_in),
		.clearing (clearing),
		.q_st     (q_st),
		.push     (push),
		.push_job (push_job)
	);

	kef_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_st     (q_st)
	);

	kef_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_st     (q_st),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

// ----- sv/kef_front.sv -----
// Front end of the Kruskal edge filter: takes an item, classifies it and
// hands it to the job queue. Depends on kef_pkg.
`timescale 1ns / 1ps

module kef_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kef_pkg::edge_in_t edge_in,
	input  logic              clearing,
	input  kef_pkg::q_stat_t  q_st,
	output logic              push,
	output kef_pkg::job_t     push_job
);
	import kef_pkg::*;

	logic     valid_s1;
	job_t     job_s1;
	logic     load;
	logic     range_ok;

	assign busy     = clearing || (valid_s1 && q_st.full);
	assign load     = start && !busy;
	assign push     = valid_s1 && !q_st.full;
	assign push_job = job_s1;

	assign range_ok = ({1'b0, edge_in.end_a} < VTX_LIMIT) &&
		({1'b0, edge_in.end_b} < VTX_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// A self loop or a vertex out of range is rejected without a root walk.
	always_ff @(posedge clk) begin
		if (load) begin
			job_s1.e    <= edge_in;
			job_s1.skip <= !range_ok || (edge_in.end_a == edge_in.end_b);
		end
	end

endmodule

// ----- sv/kef_fifo.sv -----
// Two-entry job queue between the front and back of the edge filter.
// Depends on kef_pkg.
`timescale 1ns / 1ps

module kef_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kef_pkg::job_t    push_job,
	input  logic             pop,
	output kef_pkg::job_t    head,
	output kef_pkg::q_stat_t q_st
);
	import kef_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head       = slot_q[rd_ptr_q];
	assign q_st.full  = (count_q == 2'd2);
	assign q_st.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ----- sv/kef_back.sv -----
// Back end of the edge filter: the disjoint-set forest memory, the root
// walks, the union by rank, the clearing pass and the result register.
// Depends on kef_pkg.
`timescale 1ns / 1ps

module kef_back (
	input  logic               clk,
	input  logic               arst_n,
	input  kef_pkg::q_stat_t   q_st,
	input  kef_pkg::job_t      head,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output kef_pkg::edge_out_t result
);
	import kef_pkg::*;

	typedef struct packed {
		logic              root;
		logic [RANK_W-1:0] rank;
		logic [IDX_W-1:0]  parent;
	} node_t;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_WALK_A = 3'd2;
	localparam logic [2:0] S_WALK_B = 3'd3;
	localparam logic [2:0] S_BUMP   = 3'd4;
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(VERTICES - 1);

	node_t             mem [VERTICES];
	node_t             rd_q;
	logic [2:0]        state_q;
	logic [2:0]        next_state;
	logic [IDX_W-1:0]  clr_q;
	logic [IDX_W-1:0]  w_q;
	logic [IDX_W-1:0]  ra_q;
	logic [RANK_W-1:0] rank_a_q;
	job_t              job_q;
	logic              done_q;
	edge_out_t         res_q;

	logic              load_job;
	logic              emit;
	logic              emit_tree;
	edge_in_t          emit_src;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	node_t             wr_data;
	logic [RANK_W-1:0] rank_bumped;

	assign clearing    = (state_q == S_CLEAR);
	assign done        = done_q;
	assign result      = res_q;
	assign rank_bumped = (rank_a_q == RANK_MAX) ? rank_a_q : rank_a_q + 1'b1;

	always_comb begin
		next_state = state_q;
		rd_addr    = w_q;
		wr_en      = 1'b0;
		wr_addr    = clr_q;
		wr_data    = '{root: 1'b1, rank: '0, parent: '0};
		pop        = 1'b0;
		load_job   = 1'b0;
		emit       = 1'b0;
		emit_tree  = 1'b0;
		emit_src   = job_q.e;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				if (clr_q == CLR_LAST) begin
					next_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_st.empty) begin
					pop      = 1'b1;
					load_job = 1'b1;
					if (head.skip) begin
						emit       = 1'b1;
						emit_src   = head.e;
						next_state = head.e.final_edge ? S_CLEAR : S_IDLE;
					end else begin
						rd_addr    = vidx(head.e.end_a);
						next_state = S_WALK_A;
					end
				end
			end
			S_WALK_A: begin
				if (rd_q.root) begin
					rd_addr    = vidx(job_q.e.end_b);
					next_state = S_WALK_B;
				end else begin
					rd_addr = rd_q.parent;
				end
			end
			S_WALK_B: begin
				if (!rd_q.root) begin
					rd_addr = rd_q.parent;
				end else if (w_q == ra_q) begin
					emit       = 1'b1;
					next_state = job_q.e.final_edge ? S_CLEAR : S_IDLE;
				end else begin
					wr_en = 1'b1;
					if (rank_a_q > rd_q.rank) begin
						wr_addr    = w_q;
						wr_data    = '{root: 1'b0, rank: rd_q.rank, parent: ra_q};
						emit       = 1'b1;
						emit_tree  = 1'b1;
						next_state = job_q.e.final_edge ? S_CLEAR : S_IDLE;
					end else if (rd_q.rank > rank_a_q) begin
						wr_addr    = ra_q;
						wr_data    = '{root: 1'b0, rank: rank_a_q, parent: w_q};
						emit       = 1'b1;
						emit_tree  = 1'b1;
						next_state = job_q.e.final_edge ? S_CLEAR : S_IDLE;
					end else begin
						// Equal ranks: the root of end_a wins and its rank goes up next.
						wr_addr    = w_q;
						wr_data    = '{root: 1'b0, rank: rd_q.rank, parent: ra_q};
						next_state = S_BUMP;
					end
				end
			end
			S_BUMP: begin
				wr_en      = 1'b1;
				wr_addr    = ra_q;
				wr_data    = '{root: 1'b1, rank: rank_bumped, parent: '0};
				emit       = 1'b1;
				emit_tree  = 1'b1;
				next_state = job_q.e.final_edge ? S_CLEAR : S_IDLE;
			end
			default: begin
				next_state = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= next_state;
			clr_q   <= (state_q == S_CLEAR) ? clr_q + 1'b1 : '0;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		w_q <= rd_addr;
		if (load_job) begin
			job_q <= head;
		end
		if (state_q == S_WALK_A && rd_q.root) begin
			ra_q     <= w_q;
			rank_a_q <= rd_q.rank;
		end
		if (emit) begin
			res_q.tree_edge  <= emit_tree;
			res_q.out_end_a  <= emit_src.end_a;
			res_q.out_end_b  <= emit_src.end_b;
			res_q.out_weight <= emit_src.weight;
			res_q.out_final  <= emit_src.final_edge;
		end
	end

	// Forest memory: at most one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

endmodule
